// File: design/sha256_pkg.sv
// Shared constants, state encoding and round functions for the SHA-256 hasher.
package sha256_pkg;

	localparam int unsigned BLOCK_BITS = 512;
	localparam int unsigned WORD_BITS  = 32;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_FILL = 6'd56;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PAD   = 6'b000010,
		ST_LEN   = 6'b000100,
		ST_ROUND = 6'b001000,
		ST_ADD   = 6'b010000,
		ST_EMIT  = 6'b100000
	} sha_state_t;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

// File: design/sha256_hasher.sv
// Streaming SHA-256 hasher: byte gathering, padding, round sequencer and digest output.
//
//   channel | handshake            | payload                               | role
//   cmd     | cmd_valid, cmd_stall | command, data_byte                    | request in
//   res     | res_valid, res_stall | digest_word, word_index, last_word    | result out
//
// An append request is taken while idle; the byte that completes a block starts 64 rounds
// on the single round unit, then the working words are folded into the chain.
// A finish request pushes 9 to 72 padding and length bytes at one a cycle, runs one or
// two compressions, then offers the eight digest words, one per cycle when res is not stalled.
// cmd_stall is high from the finish until the eighth word sits in the output register.
// After reset the chain holds the initial hash values and no bytes are held.
module sha256_hasher
	import sha256_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic        command,
	input  logic [7:0]  data_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	sha_state_t st_q;
	logic [5:0]  fill_q;
	logic [5:0]  rnd_q;
	logic [2:0]  lcnt_q;
	logic [2:0]  ecnt_q;
	logic        fin_q;
	logic        done_q;
	logic        pad_first_q;
	logic [63:0] msg_bits_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [BLOCK_BITS-1:0] blk_q;
	logic        res_valid_q;
	logic [31:0] digest_q;
	logic [2:0]  index_q;
	logic        last_q;

	logic        push_en;
	logic [7:0]  push_b;
	logic        blk_full;
	logic        emit_load;
	logic [31:0] w0, w1, w9, w14;
	logic [31:0] sched_w;
	logic [31:0] t1, t2;
	logic [31:0] ch_v, maj_v;

	assign cmd_stall = (st_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign digest_word = digest_q;
	assign word_index = index_q;
	assign last_word = last_q;

	always_comb begin
		push_en = 1'b0;
		push_b  = data_byte;
		unique case (st_q)
			ST_IDLE: begin
				push_en = cmd_valid && !command;
			end
			ST_PAD: begin
				push_en = 1'b1;
				push_b  = pad_first_q ? PAD_MARK : 8'h00;
			end
			ST_LEN: begin
				push_en = 1'b1;
				push_b  = msg_bits_q[{~lcnt_q, 3'b000} +: 8];
			end
			default: begin
				push_en = 1'b0;
			end
		endcase
	end

	assign blk_full  = push_en && (fill_q == 6'd63);
	assign emit_load = (st_q == ST_EMIT) && (!res_valid_q || !res_stall);

	// Window taps: word 0 is the oldest schedule word.
	assign w0  = blk_q[BLOCK_BITS-1 -: WORD_BITS];
	assign w1  = blk_q[BLOCK_BITS-1-WORD_BITS -: WORD_BITS];
	assign w9  = blk_q[BLOCK_BITS-1-9*WORD_BITS -: WORD_BITS];
	assign w14 = blk_q[BLOCK_BITS-1-14*WORD_BITS -: WORD_BITS];

	assign sched_w = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;
	assign ch_v    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj_v   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1      = v_q[7] + big_sigma1(v_q[4]) + ch_v + ROUND_K[rnd_q] + w0;
	assign t2      = big_sigma0(v_q[0]) + maj_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			fill_q      <= '0;
			rnd_q       <= '0;
			lcnt_q      <= '0;
			ecnt_q      <= '0;
			fin_q       <= 1'b0;
			done_q      <= 1'b0;
			pad_first_q <= 1'b0;
			msg_bits_q  <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= INIT_H[i];
			end
		end else begin
			if (push_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (emit_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (cmd_valid && !command) begin
						msg_bits_q <= msg_bits_q + 64'd8;
						if (blk_full) begin
							st_q <= ST_ROUND;
						end
					end else if (cmd_valid) begin
						fin_q       <= 1'b1;
						pad_first_q <= 1'b1;
						st_q        <= ST_PAD;
					end
				end
				ST_PAD: begin
					pad_first_q <= 1'b0;
					if (blk_full) begin
						st_q <= ST_ROUND;
					end else if (fill_q + 6'd1 == LEN_FILL) begin
						lcnt_q <= '0;
						st_q   <= ST_LEN;
					end
				end
				ST_LEN: begin
					lcnt_q <= lcnt_q + 3'd1;
					if (blk_full) begin
						done_q <= 1'b1;
						st_q   <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						st_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
					priority if (done_q) begin
						ecnt_q <= '0;
						st_q   <= ST_EMIT;
					end else if (fin_q) begin
						st_q <= ST_PAD;
					end else begin
						st_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						ecnt_q <= ecnt_q + 3'd1;
						if (ecnt_q == 3'd7) begin
							// word 7 is in the output register: start a fresh message
							for (int i = 0; i < 8; i++) begin
								h_q[i] <= INIT_H[i];
							end
							msg_bits_q <= '0;
							fin_q      <= 1'b0;
							done_q     <= 1'b0;
							st_q       <= ST_IDLE;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			blk_q <= {blk_q[BLOCK_BITS-9:0], push_b};
		end else if (st_q == ST_ROUND) begin
			blk_q <= {blk_q[BLOCK_BITS-WORD_BITS-1:0], sched_w};
		end
		if (blk_full) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (st_q == ST_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (emit_load) begin
			digest_q <= h_q[ecnt_q];
			index_q  <= ecnt_q;
			last_q   <= (ecnt_q == 3'd7);
		end
	end

	a_round_starts_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(st_q == ST_ROUND) |-> rnd_q == 6'd0)
		else $error("compression started with a nonzero round count");

	a_len_after_fill: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_LEN |-> fill_q[5:3] == 3'b111 && fill_q[2:0] == lcnt_q)
		else $error("length bytes out of place in the block");

	a_emit_on_empty_block: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_EMIT |-> fill_q == 6'd0 && done_q)
		else $error("digest offered with bytes still held");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(st_q == ST_EMIT))
		else $error("result raised outside digest output");

	a_last_is_seventh: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && last_q |-> index_q == 3'd7)
		else $error("last word flag on wrong index");

endmodule
